// ===== sv/rtpa2u_pkg.sv =====
// Shared constants, types and the A-law to mu-law mapping for the RTP rewriter.
package rtpa2u_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_MATCH_PORT  = 2'd0;
  localparam logic [1:0] CFG_MATCH_PT    = 2'd1;
  localparam logic [1:0] CFG_SAMPLES     = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Fixed header positions within the Ethernet frame
  localparam int unsigned POS_TYPE_LO = 13;
  localparam int unsigned POS_PROTO   = 23;
  localparam int unsigned POS_PORT_LO = 37;
  localparam int unsigned POS_RTP_MPT = 43;
  localparam int unsigned POS_PAYLOAD = 54;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_PROTO_UDP   = 8'd17;
  localparam logic [7:0]  ALAW_XOR       = 8'h55;
  localparam logic [6:0]  ULAW_XOR       = 7'h7f;

  localparam logic [15:0] RST_MATCH_PORT = 16'd1026;
  localparam logic [6:0]  RST_MATCH_PT   = 7'd8;
  localparam logic [9:0]  RST_SAMPLES    = 10'd160;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       changed;
  } res_t;

  // Magnitude step of the A-law to mu-law mapping
  function automatic logic [6:0] law_step(input logic [6:0] m);
    logic [7:0] mm;
    logic [7:0] r;
    mm = {1'b0, m};
    if (mm < 8'd8)       r = {mm[6:0], 1'b1};
    else if (mm < 8'd23) r = mm + 8'd8;
    else if (mm < 8'd31) r = mm + ((8'd32 - mm) >> 1) + 8'd4;
    else if (mm < 8'd45) r = mm + 8'd4;
    else if (mm < 8'd47) r = mm + 8'd3;
    else if (mm < 8'd63) r = mm + 8'd2;
    else if (mm < 8'd80) r = mm + 8'd1;
    else                 r = mm;
    return r[6:0];
  endfunction

  function automatic logic [7:0] alaw_to_ulaw(input logic [7:0] a);
    logic [7:0] v;
    v = a ^ ALAW_XOR;
    return {v[7], law_step(v[6:0]) ^ ULAW_XOR};
  endfunction

endpackage

// ===== sv/rtp_alaw_to_ulaw_rewriter.sv =====
// Top level: RTP A-law to mu-law rewriter on an Ethernet byte stream.
// Takes one byte per clock while in_tready is high and returns it through
// the output register, unchanged or rewritten (out_tuser flags rewrites). The
// per-byte header compare and the mapping sit between the input side and the
// output register; a one-entry skid stage behind it keeps in_tready high while
// a result waits, so a stall on the output side costs no input cycle until
// both the output and skid registers are full. Sustained rate: 1 byte/cycle.
// Header offsets are fixed (IPv4 header taken as 20 bytes); the offset counter
// saturates at 2^OFFSET_BITS-1, and bytes at that offset pass unchanged.
module rtp_alaw_to_ulaw_rewriter #(
  parameter int unsigned OFFSET_BITS = 11
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [rtpa2u_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rtpa2u_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [7:0]                           in_tdata,   // [7:0] in_byte
  input  logic                                 in_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [7:0]                           out_tdata,  // [7:0] out_byte
  output logic                                 out_tlast,
  output logic                                 out_tuser   // [0] out_changed
);

  localparam int unsigned CMP_W = (OFFSET_BITS > 10) ? OFFSET_BITS : 10;
  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  // configuration
  logic [15:0] match_port_r;
  logic [6:0]  match_pt_r;
  logic [9:0]  samples_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_port_r <= rtpa2u_pkg::RST_MATCH_PORT;
      match_pt_r   <= rtpa2u_pkg::RST_MATCH_PT;
      samples_r    <= rtpa2u_pkg::RST_SAMPLES;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rtpa2u_pkg::CFG_MATCH_PORT: match_port_r <= cfg_wdata;
        rtpa2u_pkg::CFG_MATCH_PT:   match_pt_r   <= cfg_wdata[6:0];
        rtpa2u_pkg::CFG_SAMPLES:    samples_r    <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // frame state
  logic [OFFSET_BITS-1:0] offset_r, offset_nxt;
  logic                   hdr_ok_r, hdr_ok_nxt;
  logic                   pay_en_r, pay_en_nxt;
  logic [7:0]             prev_r, prev_nxt;

  logic                   accept;
  rtpa2u_pkg::res_t       res;

  logic [15:0]            pair;
  logic                   real_off;
  logic [CMP_W-1:0]       off_ext;
  logic [CMP_W-1:0]       pay_idx;
  logic                   in_payload;

  always_comb begin
    pair       = {prev_r, in_tdata};
    real_off   = (offset_r != OFF_MAX);
    off_ext    = CMP_W'(offset_r);
    pay_idx    = off_ext - CMP_W'(rtpa2u_pkg::POS_PAYLOAD);
    in_payload = (off_ext >= CMP_W'(rtpa2u_pkg::POS_PAYLOAD)) &&
                 (pay_idx < CMP_W'(samples_r));

    res.data    = in_tdata;
    res.last    = in_tlast;
    res.changed = 1'b0;
    hdr_ok_nxt  = hdr_ok_r;
    pay_en_nxt  = pay_en_r;

    if (real_off) begin
      if (off_ext == CMP_W'(rtpa2u_pkg::POS_TYPE_LO) && pair != rtpa2u_pkg::ETHERTYPE_IPV4)
        hdr_ok_nxt = 1'b0;
      if (off_ext == CMP_W'(rtpa2u_pkg::POS_PROTO) && in_tdata != rtpa2u_pkg::IP_PROTO_UDP)
        hdr_ok_nxt = 1'b0;
      if (off_ext == CMP_W'(rtpa2u_pkg::POS_PORT_LO) && pair != match_port_r)
        hdr_ok_nxt = 1'b0;
      // keep only the marker bit of the RTP byte
      if (off_ext == CMP_W'(rtpa2u_pkg::POS_RTP_MPT) && hdr_ok_r &&
          in_tdata[6:0] == match_pt_r) begin
        res.data    = {in_tdata[7], 7'd0};
        res.changed = 1'b1;
        pay_en_nxt  = 1'b1;
      end
      if (pay_en_r && in_payload) begin
        res.data    = rtpa2u_pkg::alaw_to_ulaw(in_tdata);
        res.changed = 1'b1;
      end
    end

    if (in_tlast) begin
      offset_nxt = '0;
      hdr_ok_nxt = 1'b1;
      pay_en_nxt = 1'b0;
      prev_nxt   = 8'd0;
    end else begin
      prev_nxt   = in_tdata;
      offset_nxt = real_off ? offset_r + 1'b1 : offset_r;
    end
  end

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= '0;
      hdr_ok_r <= 1'b1;
      pay_en_r <= 1'b0;
      prev_r   <= 8'd0;
    end else if (accept) begin
      offset_r <= offset_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      pay_en_r <= pay_en_nxt;
      prev_r   <= prev_nxt;
    end
  end

  // output register with skid stage
  rtpa2u_pkg::res_t out_r, skid_r;
  logic             out_vld_r, skid_vld_r;

  assign in_tready = !skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r  <= accept;
      end
    end else if (accept) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || out_tready) begin
      if (skid_vld_r) out_r <= skid_r;
      else if (accept) out_r <= res;
    end else if (accept) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r.data;
  assign out_tlast  = out_r.last;
  assign out_tuser  = out_r.changed;

endmodule

// ===== tb/rtp_rewrite_monitor.sv =====
// Channel monitor for the RTP A-law to mu-law rewriter: config, prediction, compare.
module rtp_rewrite_monitor #(
  parameter int unsigned OFFSET_BITS = 11
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [rtpa2u_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtpa2u_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [7:0]                        in_tdata,
  input  logic                              in_tlast,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [7:0]                        out_tdata,
  input  logic                              out_tlast,
  input  logic                              out_tuser,
  output int                                fail_count,
  output int                                pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [OFFSET_BITS-1:0] OFFSET_SAT = '1;

  logic [15:0]            port_r;
  logic [6:0]             pt_r;
  logic [9:0]             samples_r;
  logic [OFFSET_BITS-1:0] offset;
  logic                   hdr_ok;
  logic                   pt_hit;
  logic [7:0]             prev_byte;
  rtpa2u_pkg::res_t       predicted_bytes[$];
  int                     errors = 0;

  function automatic logic [7:0] ulaw_of_alaw(input logic [7:0] a);
    logic [7:0] v;
    int         m;
    int         s;
    v = a ^ 8'h55;
    m = int'(v[6:0]);
    if (m < 8)       s = 2 * m + 1;
    else if (m < 23) s = m + 8;
    else if (m < 31) s = m + (32 - m) / 2 + 4;
    else if (m < 45) s = m + 4;
    else if (m < 47) s = m + 3;
    else if (m < 63) s = m + 2;
    else if (m < 80) s = m + 1;
    else             s = m;
    return {v[7], 7'(s) ^ 7'h7f};
  endfunction

  // Works out the outgoing byte for one input transfer and advances the frame state
  task automatic rewrite_byte(input logic [7:0] b, input logic last);
    rtpa2u_pkg::res_t r;
    int               pos;
    pos       = int'(offset);
    r.data    = b;
    r.last    = last;
    r.changed = 1'b0;
    // a byte at the saturated offset lies past every header and payload position
    if (offset != OFFSET_SAT) begin
      if (pos == rtpa2u_pkg::POS_TYPE_LO && {prev_byte, b} != rtpa2u_pkg::ETHERTYPE_IPV4)
        hdr_ok = 1'b0;
      if (pos == rtpa2u_pkg::POS_PROTO && b != rtpa2u_pkg::IP_PROTO_UDP) hdr_ok = 1'b0;
      if (pos == rtpa2u_pkg::POS_PORT_LO && {prev_byte, b} != port_r) hdr_ok = 1'b0;
      if (pos == rtpa2u_pkg::POS_RTP_MPT && hdr_ok && b[6:0] == pt_r) begin
        r.data    = {b[7], 7'd0};
        r.changed = 1'b1;
        pt_hit    = 1'b1;
      end
      if (pt_hit && pos >= rtpa2u_pkg::POS_PAYLOAD &&
          pos - rtpa2u_pkg::POS_PAYLOAD < samples_r) begin
        r.data    = ulaw_of_alaw(b);
        r.changed = 1'b1;
      end
    end
    predicted_bytes.push_back(r);
    if (last) begin
      offset    = '0;
      hdr_ok    = 1'b1;
      pt_hit    = 1'b0;
      prev_byte = '0;
    end else begin
      prev_byte = b;
      if (offset != OFFSET_SAT) offset++;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    rtpa2u_pkg::res_t want;
    if (!rst_n) begin
      port_r    = rtpa2u_pkg::RST_MATCH_PORT;
      pt_r      = rtpa2u_pkg::RST_MATCH_PT;
      samples_r = rtpa2u_pkg::RST_SAMPLES;
      offset    = '0;
      hdr_ok    = 1'b1;
      pt_hit    = 1'b0;
      prev_byte = '0;
      predicted_bytes.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          rtpa2u_pkg::CFG_MATCH_PORT: port_r = cfg_wdata;
          rtpa2u_pkg::CFG_MATCH_PT:   pt_r = cfg_wdata[6:0];
          rtpa2u_pkg::CFG_SAMPLES:    samples_r = cfg_wdata[9:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) rewrite_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (predicted_bytes.size() == 0) begin
          report_mismatch("transfer with nothing predicted", out_tdata, 0);
        end else begin
          want = predicted_bytes.pop_front();
          if (out_tdata != want.data) report_mismatch("out_byte", out_tdata, want.data);
          if (out_tlast != want.last) report_mismatch("out_last", out_tlast, want.last);
          if (out_tuser != want.changed)
            report_mismatch("out_changed", out_tuser, want.changed);
        end
      end
    end
    fail_count    <= errors;
    pending_count <= predicted_bytes.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the rewriter testbench: clock, reset, frame stimulus, output stalls and verdict.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 1000;
  localparam int CYCLE_LIMIT = 500000;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              cfg_wr_en = 1'b0;
  logic [rtpa2u_pkg::CFG_IDX_W-1:0]  cfg_index = rtpa2u_pkg::CFG_MATCH_PORT;
  logic [rtpa2u_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                              in_tvalid = 1'b0;
  logic                              in_tready;
  logic [7:0]                        in_tdata = '0;    // [7:0] in_byte
  logic                              in_tlast = 1'b0;
  logic                              out_tvalid;
  logic                              out_tready = 1'b0;
  logic [7:0]                        out_tdata;        // [7:0] out_byte
  logic                              out_tlast;
  logic                              out_tuser;        // [0] out_changed
  int                                failures;
  int                                pending;

  logic [15:0] cur_port = rtpa2u_pkg::RST_MATCH_PORT;
  logic [6:0]  cur_pt = rtpa2u_pkg::RST_MATCH_PT;
  logic [9:0]  cur_samples = rtpa2u_pkg::RST_SAMPLES;
  logic [7:0]  frame_q[$];
  int          sent = 0;
  int          burst_left = 0;
  bit          steady_send = 1'b0;
  int          cycles = 0;
  int          stall_mode = 0;
  int          mode_left = 0;

  rtp_alaw_to_ulaw_rewriter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  rtp_rewrite_monitor u_monitor (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .fail_count    (failures),
    .pending_count (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Receiver: stretches of full rate, light and heavy random stalls, and a fixed beat
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= (mode_left % 5 != 0);
    endcase
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady_send || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) push_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Holds the input off until every predicted byte has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] port, input logic [6:0] pt,
                              input logic [9:0] samples);
    cfg_wr_en <= 1'b1;
    cfg_index <= rtpa2u_pkg::CFG_MATCH_PORT;
    cfg_wdata <= port;
    @(posedge clk);
    cfg_index <= rtpa2u_pkg::CFG_MATCH_PT;
    cfg_wdata <= {9'd0, pt};
    @(posedge clk);
    cfg_index <= rtpa2u_pkg::CFG_SAMPLES;
    cfg_wdata <= {6'd0, samples};
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_port    = port;
    cur_pt      = pt;
    cur_samples = samples;
  endtask

  // Frame with matching headers as far as it reaches; bad_pos corrupts one header byte
  task automatic build_frame(input int len, input int bad_pos);
    logic [7:0] b;
    frame_q.delete();
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      case (i)
        rtpa2u_pkg::POS_TYPE_LO - 1: b = rtpa2u_pkg::ETHERTYPE_IPV4[15:8];
        rtpa2u_pkg::POS_TYPE_LO:     b = rtpa2u_pkg::ETHERTYPE_IPV4[7:0];
        rtpa2u_pkg::POS_PROTO:       b = rtpa2u_pkg::IP_PROTO_UDP;
        rtpa2u_pkg::POS_PORT_LO - 1: b = cur_port[15:8];
        rtpa2u_pkg::POS_PORT_LO:     b = cur_port[7:0];
        rtpa2u_pkg::POS_RTP_MPT:     b = {b[7], cur_pt};
        default: ;
      endcase
      if (i == bad_pos) begin
        if (i == rtpa2u_pkg::POS_RTP_MPT) b ^= {1'b0, 7'($urandom_range(1, 127))};
        else                              b ^= 8'($urandom_range(1, 255));
      end
      frame_q.push_back(b);
    end
  endtask

  task automatic random_frame();
    int kind;
    int plen;
    int bad;
    kind = $urandom_range(0, 9);
    plen = $urandom_range(0, int'(cur_samples) + 6);
    if (plen > 48 && $urandom_range(0, 19) != 0) plen = $urandom_range(0, 48);
    case (kind)
      6: begin
        case ($urandom_range(0, 5))
          0:       bad = rtpa2u_pkg::POS_TYPE_LO - 1;
          1:       bad = rtpa2u_pkg::POS_TYPE_LO;
          2:       bad = rtpa2u_pkg::POS_PROTO;
          3:       bad = rtpa2u_pkg::POS_PORT_LO - 1;
          4:       bad = rtpa2u_pkg::POS_PORT_LO;
          default: bad = rtpa2u_pkg::POS_RTP_MPT;
        endcase
        build_frame(rtpa2u_pkg::POS_PAYLOAD + plen, bad);
      end
      7: build_frame($urandom_range(1, rtpa2u_pkg::POS_PAYLOAD), -1);
      8: begin
        frame_q.delete();
        repeat ($urandom_range(1, 80)) frame_q.push_back(8'($urandom));
      end
      // ends inside the RTP header or right at the payload start
      9: build_frame($urandom_range(rtpa2u_pkg::POS_RTP_MPT + 1,
                                    rtpa2u_pkg::POS_PAYLOAD + 1), -1);
      default: build_frame(rtpa2u_pkg::POS_PAYLOAD + plen, -1);
    endcase
    send_frame();
  endtask

  initial begin
    int phase_start;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // single-byte frames at both byte extremes, then frames cut short at header checks
    frame_q = '{8'h00};
    send_frame();
    frame_q = '{8'hFF};
    send_frame();
    build_frame(rtpa2u_pkg::POS_TYPE_LO + 1, -1);
    send_frame();
    build_frame(rtpa2u_pkg::POS_TYPE_LO + 1, rtpa2u_pkg::POS_TYPE_LO);
    send_frame();
    drain();

    for (int phase = 0; sent < ITEM_TARGET; phase++) begin
      if (phase == 1) begin
        write_config(16'h0000, 7'd0, 10'd0);
      end else if (phase == 2) begin
        write_config(16'hFFFF, 7'h7F, 10'd1023);
      end else if (phase > 2) begin
        write_config(16'($urandom), 7'($urandom),
                     ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 1023))
                                                 : 10'($urandom_range(0, 60)));
      end
      steady_send = (phase % 3 == 2);
      phase_start = sent;
      while (sent - phase_start < 150) begin
        random_frame();
        if ($urandom_range(0, 14) == 0) drain();
      end
      drain();
    end

    drain();
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
